// File: sv/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Types and constants shared by the ray / sphere intersection unit.
// ----------------------------------------------------------------------------
package rsi_pkg;

	localparam int DIR_FRAC_BITS = 14;
	localparam int N2            = 2 * DIR_FRAC_BITS;
	localparam int DW            = 104;
	localparam int SR            = DW / 2;
	localparam int RW            = SR + 4;
	localparam int BW            = 49;

	localparam logic [1:0] REG_CX  = 2'd0;
	localparam logic [1:0] REG_CY  = 2'd1;
	localparam logic [1:0] REG_CZ  = 2'd2;
	localparam logic [1:0] REG_RAD = 2'd3;

	localparam logic [42:0] LEN_LO = 43'(998) << N2;
	localparam logic [42:0] LEN_HI = 43'(1002) << N2;
	localparam logic        SCALE_FAIL = (N2 >= 33);

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic               not_unit;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} res_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic        [30:0] rad;
	} cfg_t;

	typedef struct packed {
		logic          vld;
		logic          miss;
		logic          not_unit;
		ray_t          ray;
		logic [BW-1:0] bmag;
		logic [DW-1:0] num;
		logic [RW-1:0] rem;
		logic [SR-1:0] root;
	} sq_t;

endpackage

// File: sv/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Offset, unit check, dot products and discriminant over five stages.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_vld,
	input  ray_t ray,
	input  cfg_t cfg,
	output sq_t  out
);
	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ray_t                ray_s1, ray_s2, ray_s3, ray_s4, ray_s5;
	logic                nu_s1, nu_s2, nu_s3, nu_s4, nu_s5;
	logic signed [32:0]  vx_s1, vy_s1, vz_s1;
	logic signed [47:0]  px_s2, py_s2, pz_s2;
	logic        [65:0]  qx_s2, qy_s2, qz_s2;
	logic        [61:0]  rr_s2;
	logic signed [49:0]  b_s3;
	logic signed [68:0]  vmr_s3;
	logic                bpos_s4, bpos_s5;
	logic        [BW-1:0] bmag_s4, bmag_s5;
	logic        [49:0]  hh_s4;
	logic        [48:0]  hl_s4;
	logic        [47:0]  ll_s4;
	logic signed [96:0]  w_s4;
	logic signed [DW-1:0] disc_s5;

	logic        [32:0]  len2;
	logic        [42:0]  len1k;
	logic signed [32:0]  vx, vy, vz;
	logic        [32:0]  mx, my, mz;
	logic        [BW-1:0] bmag;
	logic        [97:0]  bsq;
	logic signed [DW-1:0] disc;

	always_comb begin
		len2 = 33'($unsigned(32'(ray.dir_x) * 32'(ray.dir_x))) +
			33'($unsigned(32'(ray.dir_y) * 32'(ray.dir_y))) +
			33'($unsigned(32'(ray.dir_z) * 32'(ray.dir_z)));
		len1k = 43'(len2) * 43'd1000;
		vx = 33'(ray.origin_x) - 33'(cfg.cx);
		vy = 33'(ray.origin_y) - 33'(cfg.cy);
		vz = 33'(ray.origin_z) - 33'(cfg.cz);
		mx = vx_s1[32] ? 33'(-vx_s1) : 33'(vx_s1);
		my = vy_s1[32] ? 33'(-vy_s1) : 33'(vy_s1);
		mz = vz_s1[32] ? 33'(-vz_s1) : 33'(vz_s1);
		bmag = b_s3[49] ? BW'(-b_s3) : BW'(b_s3);
		bsq = (98'(hh_s4) << 48) + (98'(hl_s4) << 25) + 98'(ll_s4);
		disc = $signed(DW'(bsq)) - DW'(w_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray;
			nu_s1  <= SCALE_FAIL || (len1k < LEN_LO) || (len1k > LEN_HI);
			vx_s1  <= vx;
			vy_s1  <= vy;
			vz_s1  <= vz;

			ray_s2 <= ray_s1;
			nu_s2  <= nu_s1;
			px_s2  <= 48'(vx_s1) * 48'(ray_s1.dir_x);
			py_s2  <= 48'(vy_s1) * 48'(ray_s1.dir_y);
			pz_s2  <= 48'(vz_s1) * 48'(ray_s1.dir_z);
			qx_s2  <= 66'(mx) * 66'(mx);
			qy_s2  <= 66'(my) * 66'(my);
			qz_s2  <= 66'(mz) * 66'(mz);
			rr_s2  <= 62'(cfg.rad) * 62'(cfg.rad);

			ray_s3 <= ray_s2;
			nu_s3  <= nu_s2;
			b_s3   <= 50'(px_s2) + 50'(py_s2) + 50'(pz_s2);
			vmr_s3 <= $signed(69'(qx_s2) + 69'(qy_s2) + 69'(qz_s2)) - $signed(69'(rr_s2));

			ray_s4  <= ray_s3;
			nu_s4   <= nu_s3;
			bpos_s4 <= !b_s3[49] && (b_s3 != 50'sd0);
			bmag_s4 <= bmag;
			hh_s4   <= 50'(bmag[48:24]) * 50'(bmag[48:24]);
			hl_s4   <= 49'(bmag[48:24]) * 49'(bmag[23:0]);
			ll_s4   <= 48'(bmag[23:0]) * 48'(bmag[23:0]);
			w_s4    <= 97'(vmr_s3) <<< N2;

			ray_s5  <= ray_s4;
			nu_s5   <= nu_s4;
			bpos_s5 <= bpos_s4;
			bmag_s5 <= bmag_s4;
			disc_s5 <= disc;
		end
	end

	always_comb begin
		out.vld      = vld_s5;
		out.not_unit = nu_s5;
		out.miss     = nu_s5 || disc_s5[DW-1] || bpos_s5;
		out.ray      = ray_s5;
		out.bmag     = bmag_s5;
		out.num      = disc_s5[DW-1] ? '0 : $unsigned(disc_s5);
		out.rem      = '0;
		out.root     = '0;
	end

endmodule

// File: sv/rsi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One digit step of the restoring square root, with the ray carried along.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sq_t  d,
	output sq_t  q
);
	logic [RW-1:0] rem_n, trial;
	sq_t           nxt;

	always_comb begin
		rem_n = {d.rem[RW-3:0], d.num[DW-1:DW-2]};
		trial = RW'({d.root, 2'b01});
		nxt = d;
		nxt.num = {d.num[DW-3:0], 2'b00};
		if (rem_n >= trial) begin
			nxt.rem  = rem_n - trial;
			nxt.root = {d.root[SR-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_n;
			nxt.root = {d.root[SR-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q <= '0;
		else if (en) q <= nxt;
	end

endmodule

// File: sv/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Distance along the ray, hit point and saturation into the output register.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  sq_t  d,
	output logic vld,
	output res_t res
);
	logic                vld_s1, vld_s2;
	logic                miss_s1, miss_s2, nu_s1, nu_s2;
	ray_t                ray_s1, ray_s2;
	logic        [BW-1:0] t_s1;
	logic signed [65:0]  px_s2, py_s2, pz_s2;
	logic                vld_q;
	res_t                res_q;

	function automatic logic signed [31:0] coord(logic signed [31:0] o,
		logic signed [65:0] p);
		logic signed [40:0] s;
		s = 41'(o) + 41'(p >>> N2);
		if (s > 41'sd2147483647) return 32'sh7fffffff;
		if (s < -41'sd2147483648) return 32'sh80000000;
		return 32'(s);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.vld;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			miss_s1 <= d.miss || (SR'(d.bmag) < d.root);
			nu_s1   <= d.not_unit;
			ray_s1  <= d.ray;
			t_s1    <= BW'(SR'(d.bmag) - d.root);

			miss_s2 <= miss_s1;
			nu_s2   <= nu_s1;
			ray_s2  <= ray_s1;
			px_s2   <= 66'($signed({1'b0, t_s1})) * 66'(ray_s1.dir_x);
			py_s2   <= 66'($signed({1'b0, t_s1})) * 66'(ray_s1.dir_y);
			pz_s2   <= 66'($signed({1'b0, t_s1})) * 66'(ray_s1.dir_z);

			res_q.hit      <= !miss_s2;
			res_q.not_unit <= nu_s2;
			res_q.hit_x    <= miss_s2 ? '0 : coord(ray_s2.origin_x, px_s2);
			res_q.hit_y    <= miss_s2 ? '0 : coord(ray_s2.origin_y, py_s2);
			res_q.hit_z    <= miss_s2 ? '0 : coord(ray_s2.origin_z, pz_s2);
		end
	end

	assign vld = vld_q;
	assign res = res_q;

endmodule

// File: sv/ray_sphere_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit
// Ray / sphere intersection with the nearer hit point.
// ----------------------------------------------------------------------------
// A request on the ray channel carries origin and direction; each gives
// exactly one request on the res channel, in order.
// The sphere center and radius are written on the cfg channel (index 0..3:
// center x, y, z, radius), ready is always high; write only while idle.
// The pipe is five front stages, one cell per root bit of the
// 52-bit square root, two back stages and the output register.
// Throughput is one ray per cycle while the pipe is not held; the root cell chain sets the depth.
// While the receiver stalls a held result, the whole pipe holds, empty
// slots included, and ray_stall is raised.
// Reset clears all valid bits and sets center 0, radius 1.0.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit import rsi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        ray_valid,
	output logic        ray_stall,
	input  ray_t        ray,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	cfg_t cfg_q;
	logic en;
	sq_t  chain [SR+1];

	assign en        = !res_valid || !res_stall;
	assign ray_stall = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cx  <= '0;
			cfg_q.cy  <= '0;
			cfg_q.cz  <= '0;
			cfg_q.rad <= 31'd65536;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CX:  cfg_q.cx  <= cfg_data;
				REG_CY:  cfg_q.cy  <= cfg_data;
				REG_CZ:  cfg_q.cz  <= cfg_data;
				REG_RAD: cfg_q.rad <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	rsi_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(ray_valid),
		.ray(ray), .cfg(cfg_q), .out(chain[0])
	);

	for (genvar i = 0; i < SR; i++) begin : g_cell
		rsi_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .d(chain[i]), .q(chain[i+1])
		);
	end

	rsi_back u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .d(chain[SR]),
		.vld(res_valid), .res(res)
	);

endmodule

// File: test/ray_sphere_intersect_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_intersect_unit_tb
// Self-checking bench for the ray / sphere intersection unit.
// ----------------------------------------------------------------------------
// Rays are sent on the ray channel while results are checked field by field
// against a predicted hit record, in order. Directed rays cover the unit
// length bounds, tangents, origins inside or behind the sphere and extreme
// coordinates. Random rays are mostly aimed at the sphere, the rest unaimed.
// Several sphere settings are used, extremes among them. Both sides idle at
// random; a long receiver hold fills the pipe and stalls the ray input.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_unit_tb;
	import rsi_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 80;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        ray_valid = 1'b0;
	logic        ray_stall;
	ray_t        ray = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	longint sph_cx, sph_cy, sph_cz, sph_rad;
	res_t   pending_hits[$];
	int     errors = 0;
	int     cycles = 0;
	bit     gaps_on = 1'b1;
	int     hold_cycles = 0;

	ray_sphere_intersect_unit u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= gaps_on && ($urandom_range(99) < 8);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (res_valid && !res_stall) begin
			if (pending_hits.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, res);
			end else begin
				want = pending_hits.pop_front();
				if (res.hit !== want.hit) begin
					errors++;
					$display("%0t: hit exp %b got %b", $time, want.hit, res.hit);
				end
				if (res.not_unit !== want.not_unit) begin
					errors++;
					$display("%0t: not_unit exp %b got %b", $time, want.not_unit, res.not_unit);
				end
				if (res.hit_x !== want.hit_x) begin
					errors++;
					$display("%0t: hit_x exp %h got %h", $time, want.hit_x, res.hit_x);
				end
				if (res.hit_y !== want.hit_y) begin
					errors++;
					$display("%0t: hit_y exp %h got %h", $time, want.hit_y, res.hit_y);
				end
				if (res.hit_z !== want.hit_z) begin
					errors++;
					$display("%0t: hit_z exp %h got %h", $time, want.hit_z, res.hit_z);
				end
			end
		end
	end

	function automatic logic [63:0] floor_root(logic [159:0] n);
		logic [63:0]  r;
		logic [159:0] c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = {96'b0, r | (64'd1 << i)};
			if (c * c <= n)
				r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] walk_coord(longint o, longint t, longint d);
		logic signed [95:0] p;
		p = 96'(o) + ((96'(t) * 96'(d)) >>> N2);
		if (p > 96'sd2147483647)
			return 32'h7fffffff;
		if (p < -96'sd2147483648)
			return 32'h80000000;
		return p[31:0];
	endfunction

	function automatic res_t predict_hit(ray_t r);
		res_t               o;
		longint             dx, dy, dz, vx, vy, vz, b, len2, t;
		logic signed [159:0] vv, disc;
		logic [63:0]        s;
		o = '0;
		dx = longint'(r.dir_x);
		dy = longint'(r.dir_y);
		dz = longint'(r.dir_z);
		len2 = dx * dx + dy * dy + dz * dz;
		if (SCALE_FAIL || len2 * 1000 < longint'(LEN_LO) || len2 * 1000 > longint'(LEN_HI)) begin
			o.not_unit = 1'b1;
			return o;
		end
		vx = longint'(r.origin_x) - sph_cx;
		vy = longint'(r.origin_y) - sph_cy;
		vz = longint'(r.origin_z) - sph_cz;
		b = vx * dx + vy * dy + vz * dz;
		vv = 160'(vx) * 160'(vx) + 160'(vy) * 160'(vy) + 160'(vz) * 160'(vz);
		disc = 160'(b) * 160'(b) - ((vv - 160'(sph_rad) * 160'(sph_rad)) <<< N2);
		if (disc < 0 || b > 0)
			return o;
		s = floor_root(disc);
		if (-b < longint'(s))
			return o;
		t = -b - longint'(s);
		o.hit = 1'b1;
		o.hit_x = walk_coord(longint'(r.origin_x), t, dx);
		o.hit_y = walk_coord(longint'(r.origin_y), t, dy);
		o.hit_z = walk_coord(longint'(r.origin_z), t, dz);
		return o;
	endfunction

	task automatic send_ray(ray_t r);
		ray <= r;
		ray_valid <= 1'b1;
		do @(posedge clk); while (ray_stall);
		pending_hits.push_back(predict_hit(r));
		if (gaps_on && $urandom_range(99) < 8) begin
			ray_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		ray_valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CX:  sph_cx = longint'($signed(val));
			REG_CY:  sph_cy = longint'($signed(val));
			REG_CZ:  sph_cz = longint'($signed(val));
			REG_RAD: sph_rad = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] rad);
		drain();
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
		write_reg(REG_CZ, cz);
		write_reg(REG_RAD, rad);
		cfg_valid <= 1'b0;
	endtask

	function automatic ray_t mk_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz);
		ray_t r;
		r.origin_x = ox[31:0];
		r.origin_y = oy[31:0];
		r.origin_z = oz[31:0];
		r.dir_x = dx[15:0];
		r.dir_y = dy[15:0];
		r.dir_z = dz[15:0];
		return r;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rnd_signed(int span);
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	function automatic ray_t unit_ray_at(longint ox, longint oy, longint oz);
		longint dx, dy, dz;
		dx = rnd_signed(11000);
		dy = rnd_signed(11000);
		dz = longint'(floor_root(160'((64'd1 << 28) - dx * dx - dy * dy)));
		if ($urandom_range(1))
			dz = -dz;
		case ($urandom_range(2))
			0: return mk_ray(ox, oy, oz, dx, dy, dz);
			1: return mk_ray(ox, oy, oz, dz, dx, dy);
			default: return mk_ray(ox, oy, oz, dy, dz, dx);
		endcase
	endfunction

	function automatic ray_t aimed_ray();
		ray_t   r;
		longint back, jit;
		r = unit_ray_at(0, 0, 0);
		back = sph_rad + longint'($urandom_range(1 << 22));
		jit = (sph_rad > 0) ? sph_rad : 64'd1024;
		r.origin_x = 32'(clamp32(sph_cx - ((back * r.dir_x) >>> 14) +
			rnd_signed(int'(jit / 2 + 1))));
		r.origin_y = 32'(clamp32(sph_cy - ((back * r.dir_y) >>> 14) +
			rnd_signed(int'(jit / 2 + 1))));
		r.origin_z = 32'(clamp32(sph_cz - ((back * r.dir_z) >>> 14) +
			rnd_signed(int'(jit / 2 + 1))));
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r = 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
		return r;
	endfunction

	task automatic test_directed();
		longint one;
		one = 64'd65536;
		send_ray(mk_ray(-5 * one, one, 0, 16384, 0, 0));
		send_ray(mk_ray(5 * one, one, 0, 16384, 0, 0));
		send_ray(mk_ray(-5 * one, 0, 0, 16384, 0, 0));
		send_ray(mk_ray(5 * one, 0, 0, 16384, 0, 0));
		send_ray(mk_ray(0, 0, 0, 0, 16384, 0));
		send_ray(mk_ray(0, -3 * one, 0, 0, 16384, 0));
		send_ray(mk_ray(0, 0, 3 * one, 0, 0, -16384));
		send_ray(mk_ray(-5 * one, 0, 0, 16400, 0, 0));
		send_ray(mk_ray(-5 * one, 0, 0, 16401, 0, 0));
		send_ray(mk_ray(-5 * one, 0, 0, 16368, 0, 0));
		send_ray(mk_ray(-5 * one, 0, 0, 16367, 0, 0));
		send_ray(mk_ray(-5 * one, 0, 0, 0, 0, 0));
		send_ray(mk_ray(0, 0, 0, -32768, -32768, -32768));
		send_ray(mk_ray(0, 0, 0, 32767, 32767, 32767));
		send_ray(mk_ray(64'sd2147483647, 64'sd2147483647, 64'sd2147483647,
			-9459, -9459, -9459));
		send_ray(mk_ray(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648,
			9459, 9459, 9459));
		send_ray(mk_ray(-64'sd2147483648, 0, 0, 16384, 0, 0));
		send_ray(mk_ray(0, 64'sd2147483647, 0, 0, -16384, 0));
	endtask

	task automatic test_random(int count, int aimed_pct);
		repeat (count) begin
			if ($urandom_range(99) < aimed_pct)
				send_ray(aimed_ray());
			else if ($urandom_range(1))
				send_ray(unit_ray_at(rnd_signed(1 << 20), rnd_signed(1 << 20), rnd_signed(1 << 20)));
			else
				send_ray(noise_ray());
		end
	endtask

	task automatic test_sphere_settings();
		set_sphere(32'h7fff0000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		test_directed();
		test_random(60, 80);
		set_sphere(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0);
		test_directed();
		test_random(60, 80);
		set_sphere($urandom, $urandom, $urandom, 32'h7fffffff);
		test_random(60, 80);
		set_sphere(32'h00030000, 32'hfffd0000, 32'h00008000, 32'h00028000);
		test_random(60, 80);
	endtask

	task automatic test_no_gaps();
		gaps_on = 1'b0;
		test_random(150, 75);
		gaps_on = 1'b1;
	endtask

	task automatic test_backpressure();
		hold_cycles = 250;
		test_random(150, 75);
		drain();
		test_random(30, 75);
	endtask

	initial begin
		sph_cx = 0;
		sph_cy = 0;
		sph_cz = 0;
		sph_rad = 65536;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(120, 75);
		test_sphere_settings();
		set_sphere(32'hffff0000, 32'h00020000, 32'h0, 32'h00050000);
		test_no_gaps();
		test_backpressure();
		test_random(120, 70);
		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
